@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ hdl/sha_pkg.sv @@
`timescale 1ns / 1ps
package sha_pkg;
  localparam int BlockBytes = 64;
  localparam int PadStart = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       no_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef struct packed {
    logic       start;
    logic       busy;
  } core_ctl_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction
endpackage

@@ hdl/sha_core.sv @@
`timescale 1ns / 1ps
// Compression engine: loads the block memory, then runs 64 rounds with
// the schedule window held in a 16-entry register ring.
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  input  logic        init_chain,
  output logic [3:0]  rd_addr,
  input  logic [31:0] rd_word,
  output logic        done,
  input  logic [2:0]  h_sel,
  output logic [31:0] h_word
);
  typedef enum logic [1:0] {IDLE, LOAD, ROUND, FOLD} state_t;
  state_t state;
  logic [6:0] cnt;
  logic [31:0] hv [8];
  logic [31:0] wv [8];
  logic [31:0] sw [16];
  logic [31:0] w_cur, t1, t2, sig1, ch, sig0, maj, w15, w2, w_new;
  logic [5:0] r;

  assign r = cnt[5:0];
  assign rd_addr = cnt[3:0];
  assign h_word = hv[h_sel];

  always_comb begin
    w15 = sw[4'(r + 6'd1)];
    w2 = sw[4'(r + 6'd14)];
    w_new = sw[r[3:0]] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) +
            sw[4'(r + 6'd9)] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
    w_cur = (r < 6'd16) ? sw[r[3:0]] : w_new;
    sig1 = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
    ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1 = wv[7] + sig1 + ch + RoundK[r] + w_cur;
    sig0 = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t2 = sig0 + maj;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      for (int i = 0; i < 8; i++) hv[i] <= InitH[i];
    end else begin
      unique case (state)
        IDLE: begin
          if (init_chain) for (int i = 0; i < 8; i++) hv[i] <= InitH[i];
          if (ctl.start) begin
            state <= LOAD;
            cnt <= '0;
          end
        end
        LOAD: begin
          // Memory read data is registered, so it lags the address.
          if (cnt != 7'd0) sw[4'(cnt - 7'd1)] <= rd_word;
          if (cnt == 7'd16) begin
            state <= ROUND;
            cnt <= '0;
            for (int i = 0; i < 8; i++) wv[i] <= hv[i];
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        ROUND: begin
          sw[r[3:0]] <= w_cur;
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          if (cnt == 7'd63) state <= FOLD;
          cnt <= cnt + 7'd1;
        end
        FOLD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + wv[i];
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ hdl/sha256_message_digest.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload     Handshake
// in       in   in_beat_t   in_valid / in_stall
// out      out  out_beat_t  out_valid / out_stall
// Bytes enter at one per cycle unless stalled; a full block then stalls input
// while the core loads it, runs 64 rounds, folds and hands off. A last beat adds
// padding at one byte per cycle, one or two compressions (which pause it), and
// eight digest beats. Reset is synchronous and restores the initial chain.
// in_stall is high outside byte intake; out_stall holds the current beat.
module sha256_message_digest
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);
`include "assert_macros.svh"
  typedef enum logic [2:0] {S_IN, S_COMP, S_MARK, S_ZERO, S_LEN, S_OUT} state_t;
  state_t state;
  logic [31:0] mem [BlockBytes / 4];
  logic [31:0] rd_word;
  logic [5:0] pos;
  logic [60:0] nbytes;
  logic fin, marked, final_blk, init_chain, done;
  logic [2:0] oidx;
  logic [3:0] rd_addr;
  logic [63:0] bits;
  logic we;
  logic [5:0] waddr;
  logic [7:0] wdata;
  core_ctl_t ctl;
  logic [31:0] h_word;

  assign bits = {nbytes, 3'b000};
  assign in_stall = (state != S_IN);

  always_ff @(posedge clk) begin
    if (we) mem[waddr[5:2]][{~waddr[1:0], 3'b000} +: 8] <= wdata;
    rd_word <= mem[rd_addr];
  end

  sha_core u_core (
    .clk, .rst, .ctl, .init_chain, .rd_addr, .rd_word, .done,
    .h_sel(oidx), .h_word
  );

  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = in_data.data_byte;
    ctl.start = 1'b0;
    ctl.busy = (state == S_COMP);
    unique case (state)
      S_IN: begin
        we = in_valid && !in_data.no_byte;
        ctl.start = we && pos == 6'd63;
      end
      S_MARK: begin
        we = 1'b1;
        wdata = PadByte;
        ctl.start = pos == 6'd63;
      end
      S_ZERO: begin
        we = 1'b1;
        wdata = '0;
        ctl.start = pos == 6'd63;
      end
      S_LEN: begin
        we = 1'b1;
        wdata = bits[{3'd7 - pos[2:0], 3'b000} +: 8];
        ctl.start = pos == 6'd63;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    init_chain <= 1'b0;
    if (rst) begin
      state <= S_IN;
      pos <= '0;
      nbytes <= '0;
      fin <= 1'b0;
      marked <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
      oidx <= '0;
    end else begin
      unique case (state)
        S_IN: begin
          if (in_valid) begin
            if (!in_data.no_byte) begin
              pos <= pos + 6'd1;
              nbytes <= nbytes + 61'd1;
            end
            fin <= in_data.is_last;
            if (!in_data.no_byte && pos == 6'd63) state <= S_COMP;
            else if (in_data.is_last) state <= S_MARK;
          end
        end
        S_COMP: begin
          if (done) begin
            if (final_blk) begin
              state <= S_OUT;
              out_valid <= 1'b1;
              oidx <= '0;
            end else if (!fin) state <= S_IN;
            else if (!marked) state <= S_MARK;
            else state <= S_ZERO;
          end
        end
        S_MARK: begin
          pos <= pos + 6'd1;
          marked <= 1'b1;
          if (pos == 6'd63) state <= S_COMP;
          else if (pos == 6'd55) state <= S_LEN;
          else state <= S_ZERO;
        end
        S_ZERO: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) state <= S_COMP;
          else if (pos == 6'd55) state <= S_LEN;
        end
        S_LEN: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            state <= S_COMP;
            final_blk <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              out_valid <= 1'b0;
              state <= S_IN;
              nbytes <= '0;
              fin <= 1'b0;
              marked <= 1'b0;
              final_blk <= 1'b0;
              init_chain <= 1'b1;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  always_comb begin
    out_data.digest_word = h_word;
    out_data.word_index = oidx;
    out_data.last_word = (oidx == 3'd7);
  end

  `ASSERT_IMPL(a_out_only_done, clk, rst, out_valid, state == S_OUT)
  `ASSERT_IMPL(a_stall_busy, clk, rst, ctl.busy, in_stall)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(oidx))
endmodule
